### rtl/exl_pkg.sv
// ----------------------------------------------------------------------------
// exl_pkg
// Shared types, codes and character-class helpers for the expression lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package exl_pkg;

  localparam int unsigned OUT_W = 16;

  typedef enum logic [3:0] {
    M_IDLE,
    M_COMMENT,
    M_ZERO,
    M_DEC,
    M_HEX,
    M_BIN,
    M_STRING,
    M_OPER,
    M_SYMBOL,
    M_ERROR
  } mode_e;

  // result kinds
  localparam logic [1:0] RK_TOKEN  = 2'd0;
  localparam logic [1:0] RK_ERROR  = 2'd1;
  localparam logic [1:0] RK_STATUS = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_CHAR     = 3'd1;
  localparam logic [2:0] ERR_PREFIX   = 3'd2;
  localparam logic [2:0] ERR_NUMBER   = 3'd3;
  localparam logic [2:0] ERR_OPER     = 3'd4;
  localparam logic [2:0] ERR_STRING   = 3'd5;
  localparam logic [2:0] ERR_BRACKETS = 3'd6;

  // token kinds
  localparam logic [5:0] TK_STRING = 6'd0;
  localparam logic [5:0] TK_BIN    = 6'd1;
  localparam logic [5:0] TK_DEC    = 6'd2;
  localparam logic [5:0] TK_HEX    = 6'd3;
  localparam logic [5:0] TK_BOOL   = 6'd4;
  localparam logic [5:0] TK_SYMBOL = 6'd5;
  localparam logic [5:0] TK_FUNC   = 6'd6;
  localparam logic [5:0] TK_LPAR   = 6'd7;
  localparam logic [5:0] TK_RPAR   = 6'd8;
  localparam logic [5:0] TK_LBRACE = 6'd9;
  localparam logic [5:0] TK_RBRACE = 6'd10;
  localparam logic [5:0] TK_PLUS   = 6'd11;
  localparam logic [5:0] TK_MINUS  = 6'd12;
  localparam logic [5:0] TK_STAR   = 6'd13;
  localparam logic [5:0] TK_SLASH  = 6'd14;
  localparam logic [5:0] TK_PCT    = 6'd15;
  localparam logic [5:0] TK_BOR    = 6'd16;
  localparam logic [5:0] TK_BAND   = 6'd17;
  localparam logic [5:0] TK_XOR    = 6'd18;
  localparam logic [5:0] TK_TILDE  = 6'd19;
  localparam logic [5:0] TK_LT     = 6'd20;
  localparam logic [5:0] TK_GT     = 6'd21;
  localparam logic [5:0] TK_BANG   = 6'd22;
  localparam logic [5:0] TK_ASSIGN = 6'd23;
  localparam logic [5:0] TK_COMMA  = 6'd24;
  localparam logic [5:0] TK_SEMI   = 6'd25;
  localparam logic [5:0] TK_POW    = 6'd26;
  localparam logic [5:0] TK_IDIV   = 6'd27;
  localparam logic [5:0] TK_LAND   = 6'd28;
  localparam logic [5:0] TK_LOR    = 6'd29;
  localparam logic [5:0] TK_LE     = 6'd30;
  localparam logic [5:0] TK_GE     = 6'd31;
  localparam logic [5:0] TK_NE     = 6'd32;
  localparam logic [5:0] TK_NONE   = 6'd63;

  // keyword text, first character in the low byte
  localparam logic [31:0] KW_TRUE  = {"e", "u", "r", "t"};
  localparam logic [39:0] KW_FALSE = {"e", "s", "l", "a", "f"};
  localparam logic [31:0] KW_FUNC  = {"c", "n", "u", "f"};

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  typedef struct packed {
    logic [1:0]       rkind;
    logic [5:0]       tkind;
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] len;
    logic [2:0]       err;
    logic             last;
  } res_t;

  function automatic res_t mk_res(logic [1:0] rk, logic [5:0] tk, logic [OUT_W-1:0] st,
                                  logic [OUT_W-1:0] ln, logic [2:0] er);
    res_t r;
    r.rkind = rk;
    r.tkind = tk;
    r.start = st;
    r.len   = ln;
    r.err   = er;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return (c >= "0" && c <= "9") || c == ".";
  endfunction

  function automatic logic is_hexd(logic [7:0] c);
    return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_symc(logic [7:0] c);
    return is_alpha(c) || is_dig(c) || c == "_";
  endfunction

  function automatic logic is_quote(logic [7:0] c);
    return c == 8'h27 || c == 8'h22;
  endfunction

  function automatic logic is_nl(logic [7:0] c);
    return c == 8'h0d || c == 8'h0a;
  endfunction

  function automatic logic [5:0] op_kind(logic [7:0] c);
    logic [5:0] k;
    case (c)
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      "*":     k = TK_STAR;
      "/":     k = TK_SLASH;
      "%":     k = TK_PCT;
      "|":     k = TK_BOR;
      "&":     k = TK_BAND;
      "^":     k = TK_XOR;
      "~":     k = TK_TILDE;
      "<":     k = TK_LT;
      ">":     k = TK_GT;
      "!":     k = TK_BANG;
      "=":     k = TK_ASSIGN;
      default: k = TK_NONE;
    endcase
    return k;
  endfunction

  // operators that may take a second character
  function automatic logic op_can_pair(logic [5:0] k);
    return k == TK_STAR || k == TK_SLASH || k == TK_BOR || k == TK_BAND ||
           k == TK_LT || k == TK_GT || k == TK_BANG;
  endfunction

  function automatic logic [7:0] pair_char(logic [5:0] k);
    logic [7:0] c;
    case (k)
      TK_STAR:  c = "*";
      TK_SLASH: c = "/";
      TK_BOR:   c = "|";
      TK_BAND:  c = "&";
      default:  c = "=";
    endcase
    return c;
  endfunction

  function automatic logic [5:0] pair_kind(logic [5:0] k);
    logic [5:0] p;
    case (k)
      TK_STAR:  p = TK_POW;
      TK_SLASH: p = TK_IDIV;
      TK_BOR:   p = TK_LOR;
      TK_BAND:  p = TK_LAND;
      TK_LT:    p = TK_LE;
      TK_GT:    p = TK_GE;
      default:  p = TK_NE;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

### rtl/exl_step.sv
// ----------------------------------------------------------------------------
// exl_step
// Next-state and result logic for one registered input item.
// ----------------------------------------------------------------------------
`default_nettype none

module exl_step #(
  parameter int unsigned POS_WIDTH     = 16,
  parameter int unsigned KEYWORD_CHARS = 5
) (
  input  wire logic                       req_i,
  input  wire logic [7:0]                 chr_i,
  input  exl_pkg::mode_e                  mode_i,
  input  wire logic [5:0]                 pkind_i,
  input  wire logic [POS_WIDTH-1:0]       pstart_i,
  input  wire logic [POS_WIDTH-1:0]       plen_i,
  input  wire logic [POS_WIDTH-1:0]       pos_i,
  input  wire logic [POS_WIDTH:0]         depth_i,
  input  wire logic [8*KEYWORD_CHARS-1:0] kw_i,
  output exl_pkg::mode_e                  mode_o,
  output logic [5:0]                      pkind_o,
  output logic [POS_WIDTH-1:0]            pstart_o,
  output logic [POS_WIDTH-1:0]            plen_o,
  output logic [POS_WIDTH-1:0]            pos_o,
  output logic [POS_WIDTH:0]              depth_o,
  output logic [8*KEYWORD_CHARS-1:0]      kw_o,
  output logic [1:0]                      n_o,
  output exl_pkg::res_t                   res0_o,
  output exl_pkg::res_t                   res1_o
);
  import exl_pkg::*;

  logic [POS_WIDTH-1:0] pos_inc;
  logic [POS_WIDTH-1:0] plen_inc;
  logic [OUT_W-1:0]     pos_w;
  logic [5:0]           flush_kind;
  logic [5:0]           chr_op;
  mode_e                mode_v;
  logic                 flush_v;
  logic                 fresh_v;
  logic [1:0]           n_v;
  res_t                 res_a [2];
  logic [2:0]           end_err;

  assign pos_inc  = (pos_i == '1) ? pos_i : pos_i + 1'b1;
  assign plen_inc = (plen_i == '1) ? plen_i : plen_i + 1'b1;
  assign pos_w    = OUT_W'(pos_i);
  assign chr_op   = op_kind(chr_i);

  // keyword promotion of a finished symbol
  always_comb begin
    flush_kind = pkind_i;
    if (mode_i == M_SYMBOL) begin
      if ((plen_i == POS_WIDTH'(4) && kw_i[31:0] == KW_TRUE) ||
          (plen_i == POS_WIDTH'(5) && kw_i[39:0] == KW_FALSE)) begin
        flush_kind = TK_BOOL;
      end else if (plen_i == POS_WIDTH'(4) && kw_i[31:0] == KW_FUNC) begin
        flush_kind = TK_FUNC;
      end
    end
  end

  always_comb begin
    mode_v   = mode_i;
    pkind_o  = pkind_i;
    pstart_o = pstart_i;
    plen_o   = plen_i;
    pos_o    = pos_inc;
    depth_o  = depth_i;
    kw_o     = kw_i;
    flush_v  = 1'b0;
    fresh_v  = 1'b0;
    n_v      = 2'd0;
    res_a[0] = '0;
    res_a[1] = '0;
    end_err  = ERR_NONE;

    if (req_i) begin
      // end of input: flush a pending token (a lone zero gives a prefix error), then status, then back to reset state
      if (mode_i == M_ZERO) begin
        res_a[0] = mk_res(RK_ERROR, 6'd0, pos_w, '0, ERR_PREFIX);
        n_v      = 2'd1;
        mode_v   = M_ERROR;
      end else if (mode_i == M_DEC || mode_i == M_HEX || mode_i == M_BIN ||
                   mode_i == M_OPER || mode_i == M_SYMBOL) begin
        res_a[0] = mk_res(RK_TOKEN, flush_kind, OUT_W'(pstart_i), OUT_W'(plen_i), ERR_NONE);
        n_v      = 2'd1;
        mode_v   = M_IDLE;
      end
      if (mode_v == M_STRING) begin
        end_err = ERR_STRING;
      end else if (mode_v != M_ERROR && depth_i != '0) begin
        end_err = ERR_BRACKETS;
      end
      res_a[n_v[0]] = mk_res(RK_STATUS, 6'd0, pos_w, '0, end_err);
      n_v      = n_v + 2'd1;
      mode_v   = M_IDLE;
      pkind_o  = '0;
      pstart_o = '0;
      plen_o   = '0;
      pos_o    = '0;
      depth_o  = '0;
      kw_o     = '0;
    end else begin
      case (mode_i)
        M_IDLE:    fresh_v = 1'b1;
        M_COMMENT: if (is_nl(chr_i)) mode_v = M_IDLE;
        M_ZERO: begin
          if (chr_i == "x" || chr_i == "X") begin
            pkind_o  = TK_HEX;
            mode_v   = M_HEX;
            pstart_o = pos_inc;
            plen_o   = '0;
          end else if (chr_i == "b" || chr_i == "B") begin
            pkind_o  = TK_BIN;
            mode_v   = M_BIN;
            pstart_o = pos_inc;
            plen_o   = '0;
          end else begin
            res_a[0] = mk_res(RK_ERROR, 6'd0, pos_w, '0, ERR_PREFIX);
            n_v      = 2'd1;
            mode_v   = M_ERROR;
          end
        end
        M_DEC, M_HEX, M_BIN: begin
          if ((mode_i == M_DEC && is_dig(chr_i)) ||
              (mode_i == M_HEX && is_hexd(chr_i)) ||
              (mode_i == M_BIN && (chr_i == "0" || chr_i == "1"))) begin
            plen_o = plen_inc;
          end else if (is_symc(chr_i)) begin
            res_a[0] = mk_res(RK_ERROR, 6'd0, pos_w, '0, ERR_NUMBER);
            n_v      = 2'd1;
            mode_v   = M_ERROR;
          end else begin
            flush_v = 1'b1;
            fresh_v = 1'b1;
          end
        end
        M_STRING: begin
          if (is_quote(chr_i)) flush_v = 1'b1;
          else plen_o = plen_inc;
        end
        M_OPER: begin
          if (chr_op != TK_NONE) begin
            if (chr_i == pair_char(pkind_i)) begin
              res_a[0] = mk_res(RK_TOKEN, pair_kind(pkind_i), OUT_W'(pstart_i),
                                OUT_W'(2), ERR_NONE);
              mode_v   = M_IDLE;
            end else begin
              res_a[0] = mk_res(RK_ERROR, 6'd0, pos_w, '0, ERR_OPER);
              mode_v   = M_ERROR;
            end
            n_v = 2'd1;
          end else begin
            flush_v = 1'b1;
            fresh_v = 1'b1;
          end
        end
        M_SYMBOL: begin
          if (is_symc(chr_i)) begin
            for (int i = 0; i < KEYWORD_CHARS; i++) begin
              if (plen_i == POS_WIDTH'(i)) kw_o[8*i +: 8] = chr_i;
            end
            plen_o = plen_inc;
          end else begin
            flush_v = 1'b1;
            fresh_v = 1'b1;
          end
        end
        default: mode_v = M_ERROR;
      endcase

      if (flush_v) begin
        res_a[0] = mk_res(RK_TOKEN, flush_kind, OUT_W'(pstart_i), OUT_W'(plen_i), ERR_NONE);
        n_v      = 2'd1;
        mode_v   = M_IDLE;
      end

      // the character starts something new
      if (fresh_v) begin
        if (chr_i == " " || chr_i == 8'h09 || is_nl(chr_i)) begin
          mode_v = M_IDLE;
        end else if (chr_i == "#") begin
          mode_v = M_COMMENT;
        end else if (is_dig(chr_i)) begin
          pkind_o  = TK_DEC;
          pstart_o = pos_i;
          if (chr_i == "0") begin
            mode_v = M_ZERO;
            plen_o = '0;
          end else begin
            mode_v = M_DEC;
            plen_o = POS_WIDTH'(1);
          end
        end else if (chr_op != TK_NONE) begin
          if (op_can_pair(chr_op)) begin
            pkind_o  = chr_op;
            pstart_o = pos_i;
            plen_o   = POS_WIDTH'(1);
            mode_v   = M_OPER;
          end else begin
            res_a[n_v[0]] = mk_res(RK_TOKEN, chr_op, pos_w, OUT_W'(1), ERR_NONE);
            n_v = n_v + 2'd1;
          end
        end else if (is_quote(chr_i)) begin
          pkind_o  = TK_STRING;
          pstart_o = pos_inc;
          plen_o   = '0;
          mode_v   = M_STRING;
        end else if (is_symc(chr_i)) begin
          pkind_o  = TK_SYMBOL;
          pstart_o = pos_i;
          plen_o   = POS_WIDTH'(1);
          mode_v   = M_SYMBOL;
          kw_o     = (8*KEYWORD_CHARS)'(chr_i);
        end else begin
          case (chr_i)
            "(", "{", ")", "}", ",", ";": begin
              case (chr_i)
                "(":     res_a[n_v[0]] = mk_res(RK_TOKEN, TK_LPAR, pos_w, OUT_W'(1), ERR_NONE);
                "{":     res_a[n_v[0]] = mk_res(RK_TOKEN, TK_LBRACE, pos_w, OUT_W'(1), ERR_NONE);
                ")":     res_a[n_v[0]] = mk_res(RK_TOKEN, TK_RPAR, pos_w, OUT_W'(1), ERR_NONE);
                "}":     res_a[n_v[0]] = mk_res(RK_TOKEN, TK_RBRACE, pos_w, OUT_W'(1), ERR_NONE);
                ",":     res_a[n_v[0]] = mk_res(RK_TOKEN, TK_COMMA, pos_w, OUT_W'(1), ERR_NONE);
                default: res_a[n_v[0]] = mk_res(RK_TOKEN, TK_SEMI, pos_w, OUT_W'(1), ERR_NONE);
              endcase
              if (chr_i == "(" || chr_i == "{") depth_o = depth_i + 1'b1;
              else if (chr_i == ")" || chr_i == "}") depth_o = depth_i - 1'b1;
            end
            default: begin
              res_a[n_v[0]] = mk_res(RK_ERROR, 6'd0, pos_w, '0, ERR_CHAR);
              mode_v = M_ERROR;
            end
          endcase
          n_v = n_v + 2'd1;
        end
      end
    end

    // flag the final result of this item
    if (n_v == 2'd1) res_a[0].last = 1'b1;
    else if (n_v == 2'd2) res_a[1].last = 1'b1;
  end

  assign mode_o = mode_v;
  assign n_o    = n_v;
  assign res0_o = res_a[0];
  assign res1_o = res_a[1];

endmodule

`default_nettype wire

### rtl/exl_fifo.sv
// ----------------------------------------------------------------------------
// exl_fifo
// Result queue: takes up to two results a cycle, hands out one a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module exl_fifo (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic [1:0] push_n_i,
  input  exl_pkg::res_t push0_i,
  input  exl_pkg::res_t push1_i,
  output logic         room_o,
  input  wire logic    pop_i,
  output logic         valid_o,
  output exl_pkg::res_t data_o
);
  import exl_pkg::*;

  res_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_q, wp_d;
  logic [FIFO_AW-1:0] rp_q, rp_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;
  logic               pop;
  logic [FIFO_AW-1:0] wp_next;

  assign valid_o = (cnt_q != '0);
  assign pop     = pop_i && valid_o;
  // two free entries are needed before the next item is processed
  assign room_o  = (cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign data_o  = mem_q[rp_q];
  assign wp_next = wp_q + 1'b1;

  always_comb begin
    wp_d  = wp_q + push_n_i[FIFO_AW-1:0];
    rp_d  = pop ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + (FIFO_AW+1)'(push_n_i) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem_q[wp_q] <= push0_i;
    if (push_n_i == 2'd2) mem_q[wp_next] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### rtl/expression_lexer.sv
// Flow: an accepted item is held in the input register, and its results are then written to
//   the result queue, from which they are offered on the output port.
// One input item per cycle while the result queue has room; an item with two results
//   leaves the single output port one per cycle, as the result queue drains one per cycle.
// Reset: rst_ni is asynchronous, active low; clears lexer state, input register and
//   result queue. The end-of-input marker also returns the lexer to its reset state.
// ----------------------------------------------------------------------------
// expression_lexer
// Streaming tokenizer: one character per transfer, tokens and status out.
// ----------------------------------------------------------------------------
`default_nettype none

module expression_lexer #(
  parameter int unsigned POS_WIDTH     = 16,
  parameter int unsigned KEYWORD_CHARS = 5
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  char_code_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       result_kind_o,
  output logic [5:0]       token_kind_o,
  output logic [15:0]      token_start_o,
  output logic [15:0]      token_length_o,
  output logic [2:0]       error_code_o,
  output logic             last_o
);
  import exl_pkg::*;

  logic                       in_valid_q, in_valid_d;
  logic                       req_q;
  logic [7:0]                 chr_q;
  logic                       adv;
  logic                       room;

  mode_e                      mode_q, mode_d;
  logic [5:0]                 pkind_q, pkind_d;
  logic [POS_WIDTH-1:0]       pstart_q, pstart_d;
  logic [POS_WIDTH-1:0]       plen_q, plen_d;
  logic [POS_WIDTH-1:0]       pos_q, pos_d;
  logic [POS_WIDTH:0]         depth_q, depth_d;
  logic [8*KEYWORD_CHARS-1:0] kw_q, kw_d;

  logic [1:0]                 n_res;
  logic [1:0]                 push_n;
  res_t                       res0, res1, head;

  assign adv        = in_valid_q && room;
  assign in_ready_o = !in_valid_q || adv;
  assign in_valid_d = (in_valid_i && in_ready_o) ? 1'b1 : (adv ? 1'b0 : in_valid_q);
  assign push_n     = adv ? n_res : 2'd0;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= req_type_i;
      chr_q <= char_code_i;
    end
  end

  exl_step #(
    .POS_WIDTH    (POS_WIDTH),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_step (
    .req_i   (req_q),
    .chr_i   (chr_q),
    .mode_i  (mode_q),
    .pkind_i (pkind_q),
    .pstart_i(pstart_q),
    .plen_i  (plen_q),
    .pos_i   (pos_q),
    .depth_i (depth_q),
    .kw_i    (kw_q),
    .mode_o  (mode_d),
    .pkind_o (pkind_d),
    .pstart_o(pstart_d),
    .plen_o  (plen_d),
    .pos_o   (pos_d),
    .depth_o (depth_d),
    .kw_o    (kw_d),
    .n_o     (n_res),
    .res0_o  (res0),
    .res1_o  (res1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      mode_q     <= M_IDLE;
      pkind_q    <= '0;
      pstart_q   <= '0;
      plen_q     <= '0;
      pos_q      <= '0;
      depth_q    <= '0;
      kw_q       <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (adv) begin
        mode_q   <= mode_d;
        pkind_q  <= pkind_d;
        pstart_q <= pstart_d;
        plen_q   <= plen_d;
        pos_q    <= pos_d;
        depth_q  <= depth_d;
        kw_q     <= kw_d;
      end
    end
  end

  exl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_n_i(push_n),
    .push0_i (res0),
    .push1_i (res1),
    .room_o  (room),
    .pop_i   (out_ready_i),
    .valid_o (out_valid_o),
    .data_o  (head)
  );

  assign result_kind_o  = head.rkind;
  assign token_kind_o   = head.tkind;
  assign token_start_o  = head.start;
  assign token_length_o = head.len;
  assign error_code_o   = head.err;
  assign last_o         = head.last;

endmodule

`default_nettype wire

### rtl/exl_checker.sv
// ----------------------------------------------------------------------------
// exl_checker
// Port-level checks on the lexer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module exl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  result_kind_o,
  input wire logic [5:0]  token_kind_o,
  input wire logic [15:0] token_start_o,
  input wire logic [15:0] token_length_o,
  input wire logic [2:0]  error_code_o,
  input wire logic        last_o
);
  import exl_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_start_o) &&
    $stable(result_kind_o) && $stable(last_o))
    else $error("result changed while stalled");

  // the end status always closes its item
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == RK_STATUS |-> last_o)
    else $error("status without last");

  // errors and status carry no token text
  a_no_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != RK_TOKEN |-> token_length_o == '0 && token_kind_o == '0)
    else $error("error or status with token fields");

  // tokens carry no error, errors carry a code
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == RK_TOKEN || result_kind_o == RK_ERROR) |->
    ((result_kind_o == RK_TOKEN) == (error_code_o == ERR_NONE)))
    else $error("error code does not match result kind");

endmodule

bind expression_lexer exl_checker u_exl_checker (.*);

`default_nettype wire

### bench/expression_lexer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_lexer_tb
// Self-checking bench for the streaming lexer. A scripted opener, a longer
// string, then random token streams under several handshake idle mixes.
// Every result is compared with an in-bench lexer or, for typed script rows, a scripted result.
// ----------------------------------------------------------------------------
module expression_lexer_tb;
  import exl_pkg::*;

  localparam logic       CHAR_ITEM   = 1'b0;
  localparam logic       END_ITEM    = 1'b1;
  localparam logic [5:0] NO_KIND     = 6'd0;
  localparam int         KW_BYTES    = 5;
  localparam int         HOLD_CYCLES = 300;
  localparam int         LONG_STRING = 40;
  localparam int         PHASE_ITEMS = 310;

  typedef struct {
    logic       eoi;
    logic [7:0] ch;
    logic       typed;
    res_t       want;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic        req_type;
  logic [7:0]  char_code;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  result_kind;
  logic [5:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [2:0]  error_code;
  logic        last;

  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_req;
  int   live_items;
  int   bad_results;
  logic row_typed;
  res_t row_want;
  row_t script[$];

  // lexer state mirrored by the bench
  mode_e       lx_mode;
  logic [5:0]  lx_kind;
  logic [15:0] lx_start;
  logic [15:0] lx_len;
  logic [15:0] lx_pos;
  logic [16:0] lx_depth;
  logic [39:0] lx_kw;
  res_t        tokens_due[$];

  expression_lexer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .req_type_i     (req_type),
    .char_code_i    (char_code),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_o  (result_kind),
    .token_kind_o   (token_kind),
    .token_start_o  (token_start),
    .token_length_o (token_length),
    .error_code_o   (error_code),
    .last_o         (last)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- lexer

  function automatic logic [15:0] bump(logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  function automatic logic c_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic c_digit(logic [7:0] c);
    return (c >= "0" && c <= "9") || c == ".";
  endfunction

  function automatic logic c_hex(logic [7:0] c);
    return c_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic c_sym(logic [7:0] c);
    return c_alpha(c) || c_digit(c) || c == "_";
  endfunction

  function automatic logic c_quote(logic [7:0] c);
    return c == 8'h22 || c == 8'h27;
  endfunction

  function automatic logic c_eol(logic [7:0] c);
    return c == 8'h0a || c == 8'h0d;
  endfunction

  function automatic logic [5:0] c_oper(logic [7:0] c);
    case (c)
      "+": return TK_PLUS;
      "-": return TK_MINUS;
      "*": return TK_STAR;
      "/": return TK_SLASH;
      "%": return TK_PCT;
      "|": return TK_BOR;
      "&": return TK_BAND;
      "^": return TK_XOR;
      "~": return TK_TILDE;
      "<": return TK_LT;
      ">": return TK_GT;
      "!": return TK_BANG;
      "=": return TK_ASSIGN;
      default: return TK_NONE;
    endcase
  endfunction

  function automatic logic op_waits(logic [5:0] k);
    return k == TK_STAR || k == TK_SLASH || k == TK_BOR || k == TK_BAND ||
           k == TK_LT || k == TK_GT || k == TK_BANG;
  endfunction

  function automatic logic [7:0] op_second(logic [5:0] k);
    case (k)
      TK_STAR:  return "*";
      TK_SLASH: return "/";
      TK_BOR:   return "|";
      TK_BAND:  return "&";
      default:  return "=";
    endcase
  endfunction

  function automatic logic [5:0] op_double(logic [5:0] k);
    case (k)
      TK_STAR:  return TK_POW;
      TK_SLASH: return TK_IDIV;
      TK_BOR:   return TK_LOR;
      TK_BAND:  return TK_LAND;
      TK_LT:    return TK_LE;
      TK_GT:    return TK_GE;
      default:  return TK_NE;
    endcase
  endfunction

  function automatic void lex_reset();
    lx_mode  = M_IDLE;
    lx_kind  = '0;
    lx_start = '0;
    lx_len   = '0;
    lx_pos   = '0;
    lx_depth = '0;
    lx_kw    = '0;
  endfunction

  function automatic void lex_emit(logic [1:0] rk, logic [5:0] tk, logic [15:0] st,
                                   logic [15:0] ln, logic [2:0] er);
    res_t r;
    r.rkind = rk;
    r.tkind = tk;
    r.start = st;
    r.len   = ln;
    r.err   = er;
    r.last  = 1'b0;
    tokens_due.push_back(r);
  endfunction

  function automatic void lex_fail(logic [15:0] pos, logic [2:0] code);
    lex_emit(RK_ERROR, NO_KIND, pos, 16'd0, code);
    lx_mode = M_ERROR;
  endfunction

  function automatic void lex_open(logic [5:0] kind, mode_e mode, logic [15:0] start,
                                   logic [15:0] len);
    lx_kind  = kind;
    lx_start = start;
    lx_len   = len;
    lx_mode  = mode;
  endfunction

  function automatic void lex_flush();
    logic [5:0] k;
    k = lx_kind;
    if (lx_mode == M_SYMBOL) begin
      if ((lx_len == 16'd4 && lx_kw[31:0] == {"e", "u", "r", "t"}) ||
          (lx_len == 16'd5 && lx_kw == {"e", "s", "l", "a", "f"}))
        k = TK_BOOL;
      else if (lx_len == 16'd4 && lx_kw[31:0] == {"c", "n", "u", "f"})
        k = TK_FUNC;
    end
    lex_emit(RK_TOKEN, k, lx_start, lx_len, ERR_NONE);
    lx_mode = M_IDLE;
  endfunction

  function automatic void lex_fresh(logic [7:0] c, logic [15:0] pos);
    logic [5:0] k;
    k = c_oper(c);
    if (c == " " || c == 8'h09 || c_eol(c)) begin
      // blank: nothing starts
    end else if (c == "#") begin
      lx_mode = M_COMMENT;
    end else if (c_digit(c)) begin
      lex_open(TK_DEC, (c == "0") ? M_ZERO : M_DEC, pos, (c == "0") ? 16'd0 : 16'd1);
    end else if (k != TK_NONE) begin
      if (op_waits(k)) lex_open(k, M_OPER, pos, 16'd1);
      else lex_emit(RK_TOKEN, k, pos, 16'd1, ERR_NONE);
    end else if (c_quote(c)) begin
      lex_open(TK_STRING, M_STRING, bump(pos), 16'd0);
    end else if (c_sym(c)) begin
      lex_open(TK_SYMBOL, M_SYMBOL, pos, 16'd1);
      lx_kw = {32'd0, c};
    end else begin
      case (c)
        "(": begin
          lex_emit(RK_TOKEN, TK_LPAR, pos, 16'd1, ERR_NONE);
          lx_depth = lx_depth + 17'd1;
        end
        "{": begin
          lex_emit(RK_TOKEN, TK_LBRACE, pos, 16'd1, ERR_NONE);
          lx_depth = lx_depth + 17'd1;
        end
        ")": begin
          lex_emit(RK_TOKEN, TK_RPAR, pos, 16'd1, ERR_NONE);
          lx_depth = lx_depth - 17'd1;
        end
        "}": begin
          lex_emit(RK_TOKEN, TK_RBRACE, pos, 16'd1, ERR_NONE);
          lx_depth = lx_depth - 17'd1;
        end
        ",": lex_emit(RK_TOKEN, TK_COMMA, pos, 16'd1, ERR_NONE);
        ";": lex_emit(RK_TOKEN, TK_SEMI, pos, 16'd1, ERR_NONE);
        default: lex_fail(pos, ERR_CHAR);
      endcase
    end
  endfunction

  function automatic void lex_number(logic [7:0] c, logic in_class, logic [15:0] pos);
    if (in_class) begin
      lx_len = bump(lx_len);
    end else if (c_sym(c)) begin
      lex_fail(pos, ERR_NUMBER);
    end else begin
      lex_flush();
      lex_fresh(c, pos);
    end
  endfunction

  // one accepted transfer: append its results to tokens_due
  function automatic void lex_item(logic eoi, logic [7:0] c);
    int          n_prior;
    logic [15:0] pos;
    logic [2:0]  err;
    n_prior = tokens_due.size();
    pos     = lx_pos;
    if (eoi) begin
      err = ERR_NONE;
      if (lx_mode == M_ZERO) lex_fail(pos, ERR_PREFIX);
      else if (lx_mode inside {M_DEC, M_HEX, M_BIN, M_OPER, M_SYMBOL}) lex_flush();
      if (lx_mode == M_STRING) err = ERR_STRING;
      else if (lx_mode != M_ERROR && lx_depth != 17'd0) err = ERR_BRACKETS;
      lex_emit(RK_STATUS, NO_KIND, pos, 16'd0, err);
      lex_reset();
    end else begin
      case (lx_mode)
        M_IDLE: lex_fresh(c, pos);
        M_COMMENT: if (c_eol(c)) lx_mode = M_IDLE;
        M_ZERO: begin
          if (c == "x" || c == "X") lex_open(TK_HEX, M_HEX, bump(pos), 16'd0);
          else if (c == "b" || c == "B") lex_open(TK_BIN, M_BIN, bump(pos), 16'd0);
          else lex_fail(pos, ERR_PREFIX);
        end
        M_DEC: lex_number(c, c_digit(c), pos);
        M_HEX: lex_number(c, c_hex(c), pos);
        M_BIN: lex_number(c, c == "0" || c == "1", pos);
        M_STRING: begin
          if (c_quote(c)) lex_flush();
          else lx_len = bump(lx_len);
        end
        M_OPER: begin
          if (c_oper(c) != TK_NONE) begin
            if (c == op_second(lx_kind)) begin
              lex_emit(RK_TOKEN, op_double(lx_kind), lx_start, 16'd2, ERR_NONE);
              lx_mode = M_IDLE;
            end else begin
              lex_fail(pos, ERR_OPER);
            end
          end else begin
            lex_flush();
            lex_fresh(c, pos);
          end
        end
        M_SYMBOL: begin
          if (c_sym(c)) begin
            if (lx_len < KW_BYTES) lx_kw = lx_kw | (40'(c) << (8 * lx_len));
            lx_len = bump(lx_len);
          end else begin
            lex_flush();
            lex_fresh(c, pos);
          end
        end
        default: lx_mode = M_ERROR;
      endcase
      lx_pos = bump(pos);
    end
    if (tokens_due.size() > n_prior) tokens_due[tokens_due.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic string fmt_res(res_t r);
    return $sformatf("rk %0d tk %0d start %0d len %0d err %0d last %0d",
                     r.rkind, r.tkind, r.start, r.len, r.err, r.last);
  endfunction

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && in_valid && in_ready) begin
      live_items++;
      lex_item(req_type, char_code);
      if (row_typed) tokens_due[tokens_due.size() - 1] = row_want;
    end
    if (rst_ni && out_valid && out_ready) begin
      got.rkind = result_kind;
      got.tkind = token_kind;
      got.start = token_start;
      got.len   = token_length;
      got.err   = error_code;
      got.last  = last;
      if (tokens_due.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("%0t: result with nothing pending: %s", $realtime, fmt_res(got));
      end else begin
        want = tokens_due.pop_front();
        if (got !== want) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: result differs\n  expected %s\n  actual   %s",
                     $realtime, fmt_res(want), fmt_res(got));
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- sender

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic offer(input logic eoi, input logic [7:0] c, input logic typed,
                       input res_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid  = 1'b1;
    req_type  = eoi;
    char_code = c;
    row_typed = typed;
    row_want  = want;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic put_char(input logic [7:0] c);
    offer(CHAR_ITEM, c, 1'b0, '0);
  endtask

  task automatic put_end();
    offer(END_ITEM, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (tokens_due.size() != 0) @(negedge clk_i);
  endtask

  function automatic void script_row(logic eoi, logic [7:0] ch, logic typed, res_t want);
    row_t r;
    r.eoi   = eoi;
    r.ch    = ch;
    r.typed = typed;
    r.want  = want;
    script.push_back(r);
  endfunction

  function automatic res_t res_of(logic [1:0] rk, logic [5:0] tk, logic [15:0] st,
                                  logic [15:0] ln, logic [2:0] er);
    res_t r;
    r.rkind = rk;
    r.tkind = tk;
    r.start = st;
    r.len   = ln;
    r.err   = er;
    r.last  = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] sym_first();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'(r + 8'h61);
    if (r < 52) return 8'(r - 26 + 8'h41);
    return "_";
  endfunction

  function automatic logic [7:0] sym_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 53) return sym_first();
    if (r < 63) return 8'(r - 53 + 8'h30);
    return ".";
  endfunction

  function automatic logic [7:0] hex_char();
    int r;
    r = $urandom_range(0, 22);
    if (r < 10) return 8'(r + 8'h30);
    if (r < 16) return 8'(r - 10 + 8'h61);
    if (r < 22) return 8'(r - 16 + 8'h41);
    return ".";
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return " ";
      1: return 8'h09;
      2: return 8'h0a;
      default: return 8'h0d;
    endcase
  endfunction

  function automatic logic [7:0] any_quote();
    return $urandom_range(0, 1) ? 8'h22 : 8'h27;
  endfunction

  task automatic send_token();
    int         pick;
    int         n;
    logic [7:0] c;
    string      word;
    string      ops;
    string      punct;
    ops   = "+-*/%|&^~<>!=";
    punct = "(){},;";
    pick  = $urandom_range(0, 99);
    if (pick < 20) begin
      case ($urandom_range(0, 5))
        0: word = "true";
        1: word = "false";
        2: word = "func";
        default: word = "";
      endcase
      if (word.len() != 0) begin
        foreach (word[i]) put_char(word[i]);
        if ($urandom_range(0, 4) == 0) put_char(sym_char());
      end else begin
        put_char(sym_first());
        repeat ($urandom_range(0, 6)) put_char(sym_char());
      end
    end else if (pick < 32) begin
      n = $urandom_range(0, 9);
      put_char(n == 0 ? 8'h2e : 8'(n + 8'h30));
      repeat ($urandom_range(0, 5)) begin
        n = $urandom_range(0, 10);
        put_char(n == 10 ? 8'h2e : 8'(n + 8'h30));
      end
    end else if (pick < 40) begin
      put_char("0");
      put_char($urandom_range(0, 1) ? "x" : "X");
      repeat ($urandom_range(0, 4)) put_char(hex_char());
    end else if (pick < 46) begin
      put_char("0");
      put_char($urandom_range(0, 1) ? "b" : "B");
      repeat ($urandom_range(0, 6)) put_char($urandom_range(0, 1) ? "1" : "0");
    end else if (pick < 56) begin
      put_char(any_quote());
      repeat ($urandom_range(0, 6)) begin
        do c = 8'($urandom_range(0, 255)); while (c_quote(c));
        put_char(c);
      end
      // a few strings stay open
      if ($urandom_range(0, 99) < 92) put_char(any_quote());
    end else if (pick < 80) begin
      c = ops[$urandom_range(0, 12)];
      put_char(c);
      if (op_waits(c_oper(c)) && $urandom_range(0, 1)) put_char(op_second(c_oper(c)));
    end else if (pick < 92) begin
      put_char(punct[$urandom_range(0, 5)]);
    end else if (pick < 96) begin
      put_char("#");
      repeat ($urandom_range(0, 5)) begin
        do c = 8'($urandom_range(0, 255)); while (c_eol(c));
        put_char(c);
      end
      put_char($urandom_range(0, 1) ? 8'h0a : 8'h0d);
    end else begin
      case ($urandom_range(0, 3))
        0: put_char("0");
        1: begin
          put_char("7");
          put_char(sym_first());
        end
        2: begin
          put_char("<");
          put_char(ops[$urandom_range(0, 12)]);
        end
        default: put_char(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic send_stream();
    repeat ($urandom_range(1, 14)) begin
      send_token();
      if ($urandom_range(0, 99) < 75) put_char(blank_char());
    end
    put_end();
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    int target;
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    req_type       = CHAR_ITEM;
    char_code      = 8'h00;
    row_typed      = 1'b0;
    row_want       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    lex_reset();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // end marker straight after reset
    script_row(END_ITEM, 8'h00, 1'b1, res_of(RK_STATUS, NO_KIND, 16'd0, 16'd0, ERR_NONE));
    // hex number ended by an operator, power, then a broken pair
    script_row(CHAR_ITEM, "(", 1'b1, res_of(RK_TOKEN, TK_LPAR, 16'd0, 16'd1, ERR_NONE));
    script_row(CHAR_ITEM, "0", 1'b0, '0);
    script_row(CHAR_ITEM, "x", 1'b0, '0);
    script_row(CHAR_ITEM, "f", 1'b0, '0);
    script_row(CHAR_ITEM, "*", 1'b0, '0);
    script_row(CHAR_ITEM, "*", 1'b0, '0);
    script_row(CHAR_ITEM, "<", 1'b0, '0);
    script_row(CHAR_ITEM, "+", 1'b1, res_of(RK_ERROR, NO_KIND, 16'd7, 16'd0, ERR_OPER));
    script_row(CHAR_ITEM, 8'hff, 1'b0, '0);
    // open bracket is not reported once an error was seen
    script_row(END_ITEM, 8'hff, 1'b1, res_of(RK_STATUS, NO_KIND, 16'd9, 16'd0, ERR_NONE));
    // open string
    script_row(CHAR_ITEM, 8'h22, 1'b0, '0);
    script_row(CHAR_ITEM, 8'h00, 1'b0, '0);
    script_row(END_ITEM, 8'h00, 1'b1, res_of(RK_STATUS, NO_KIND, 16'd2, 16'd0, ERR_STRING));
    // keyword, brace, pending number flushed at the end, brace left open
    script_row(CHAR_ITEM, "t", 1'b0, '0);
    script_row(CHAR_ITEM, "r", 1'b0, '0);
    script_row(CHAR_ITEM, "u", 1'b0, '0);
    script_row(CHAR_ITEM, "e", 1'b0, '0);
    script_row(CHAR_ITEM, "{", 1'b0, '0);
    script_row(CHAR_ITEM, "5", 1'b0, '0);
    script_row(END_ITEM, 8'h00, 1'b1,
               res_of(RK_STATUS, NO_KIND, 16'd6, 16'd0, ERR_BRACKETS));
    // lone zero
    script_row(CHAR_ITEM, "0", 1'b0, '0);
    script_row(CHAR_ITEM, ";", 1'b1, res_of(RK_ERROR, NO_KIND, 16'd1, 16'd0, ERR_PREFIX));
    script_row(END_ITEM, 8'h00, 1'b1, res_of(RK_STATUS, NO_KIND, 16'd2, 16'd0, ERR_NONE));
    // bad character
    script_row(CHAR_ITEM, "@", 1'b1, res_of(RK_ERROR, NO_KIND, 16'd0, 16'd0, ERR_CHAR));
    script_row(END_ITEM, 8'h00, 1'b1, res_of(RK_STATUS, NO_KIND, 16'd1, 16'd0, ERR_NONE));

    foreach (script[i]) offer(script[i].eoi, script[i].ch, script[i].typed, script[i].want);
    drain();

    // longer string, then a bracket left open
    put_char(8'h22);
    repeat (LONG_STRING) put_char("a");
    put_char(8'h22);
    put_char("(");
    put_end();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req++;  // long receiver hold while transfers keep coming
        end
        1: begin
          send_idle_pct  = 46;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 46;
        end
        default: begin
          send_idle_pct  = 32;
          recv_stall_pct = 32;
        end
      endcase
      target = live_items + PHASE_ITEMS;
      while (live_items < target) send_stream();
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (bad_results == 0 && tokens_due.size() == 0) begin
      $display("expression_lexer: match");
    end else begin
      $display("expression_lexer: mismatch");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("expression_lexer: mismatch");
    $finish;
  end

endmodule

### sim.f
rtl/exl_pkg.sv
rtl/exl_step.sv
rtl/exl_fifo.sv
rtl/expression_lexer.sv
rtl/exl_checker.sv
bench/expression_lexer_tb.sv
